[sv/alm_pkg.sv]
// Shared constants and codes for the array list engine.
package alm_pkg;

   localparam int CAPACITY      = 64;
   localparam int INITIAL_COUNT = 10;
   localparam int INIT_COUNT    = (INITIAL_COUNT > CAPACITY) ? CAPACITY : INITIAL_COUNT;
   localparam int IDX_W         = $clog2(CAPACITY);
   localparam int CNT_W         = $clog2(CAPACITY + 1);
   localparam int DATA_W        = 32;
   localparam int POS_W         = 7;
   localparam int REQ_W         = 2;
   localparam int STAT_W        = 3;

   localparam logic [REQ_W-1:0] REQ_INSERT = 2'd0;
   localparam logic [REQ_W-1:0] REQ_DELETE = 2'd1;
   localparam logic [REQ_W-1:0] REQ_SEARCH = 2'd2;
   localparam logic [REQ_W-1:0] REQ_READ   = 2'd3;

   localparam logic [STAT_W-1:0] ST_OK        = 3'd0;
   localparam logic [STAT_W-1:0] ST_NOT_FOUND = 3'd1;
   localparam logic [STAT_W-1:0] ST_FULL      = 3'd2;
   localparam logic [STAT_W-1:0] ST_BAD_POS   = 3'd3;
   localparam logic [STAT_W-1:0] ST_EMPTY     = 3'd4;

   typedef logic [IDX_W-1:0]  idx_type;
   typedef logic [CNT_W-1:0]  cnt_type;
   typedef logic [DATA_W-1:0] data_type;

endpackage

[sv/alm_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module alm_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

[sv/array_list_engine.sv]
// Top level of the array list engine: ordered list of signed words in a RAM.
//
// Requests arrive as beats on req_* (insert at a one-based position, delete
// by value, search by value, read the whole list). Results leave on rsp_*:
// one beat per request, except a read of a non-empty list, which sends one
// beat per live entry with rsp_tlast on the final one. One request is in
// work at a time. Rejected requests go straight to their result beat; a
// search or delete scans from the head of the list. A delete hit then shifts
// the later entries down one place; an insert shifts the entries from its
// position onward up one place, then writes the value. A read fetches each
// entry in turn once the output register is free. The next request is taken
// in the cycle after the final beat is placed. The list RAM has one read
// port and one write port, with registered read data.
// Reset sets the live count to ten and the whole list to zero; per-entry
// valid flops make unwritten entries read as zero, so no clearing pass runs.
// When the receiver stalls, the result beat holds in the output register
// and the sequencer waits; a new request is taken as soon as the previous
// one has placed its final beat in that register.
module array_list_engine
   import alm_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // req_type[1:0], value[33:2], position[40:34], zero pad
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // status[2:0], index[8:3], item_value[40:9], entry_count[47:41]
   output logic        rsp_tlast
);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_SCAN   = 3'd1;
   localparam logic [2:0] S_MOVE   = 3'd2;
   localparam logic [2:0] S_PUTV   = 3'd3;
   localparam logic [2:0] S_DONE   = 3'd4;
   localparam logic [2:0] S_RDISS  = 3'd5;
   localparam logic [2:0] S_RDLOAD = 3'd6;

   logic [2:0]         state_ff, state_in;
   cnt_type            count_ff, count_in;
   logic [REQ_W-1:0]   op_ff, op_in;
   data_type           value_ff, value_in;
   idx_type            ins_addr_ff, ins_addr_in;
   cnt_type            ptr_ff, ptr_in;
   cnt_type            left_ff, left_in;
   logic               pend_ff, pend_in;
   idx_type            pend_idx_ff, pend_idx_in;
   logic [STAT_W-1:0]  res_status_ff, res_status_in;
   idx_type            res_index_ff, res_index_in;
   logic [CAPACITY-1:0] valid_ff, valid_in;
   logic               rd_vld_ff;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [47:0]        rsp_data_ff, rsp_data_in;
   logic               rsp_last_ff, rsp_last_in;

   logic               ram_we, ram_re;
   idx_type            ram_waddr, ram_raddr;
   data_type           ram_wdata, ram_q, rd_word;
   logic               slot_free;

   logic [REQ_W-1:0]   in_type;
   data_type           in_value;
   logic [POS_W-1:0]   in_pos;

   assign in_type  = req_tdata[1:0];
   assign in_value = req_tdata[33:2];
   assign in_pos   = req_tdata[40:34];

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

   assign slot_free = !rsp_valid_ff || rsp_tready;
   assign rd_word   = rd_vld_ff ? ram_q : '0;

   alm_ram #(.WIDTH(DATA_W), .DEPTH(CAPACITY)) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_q)
   );

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      op_in         = op_ff;
      value_in      = value_ff;
      ins_addr_in   = ins_addr_ff;
      ptr_in        = ptr_ff;
      left_in       = left_ff;
      pend_in       = 1'b0;
      pend_idx_in   = pend_idx_ff;
      res_status_in = res_status_ff;
      res_index_in  = res_index_ff;
      valid_in      = valid_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_data_in   = rsp_data_ff;
      rsp_last_in   = rsp_last_ff;
      ram_we        = 1'b0;
      ram_waddr     = pend_idx_ff;
      ram_wdata     = rd_word;
      ram_re        = 1'b0;
      ram_raddr     = ptr_ff[IDX_W-1:0];

      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               op_in         = in_type;
               value_in      = in_value;
               res_status_in = ST_OK;
               res_index_in  = '0;
               pend_in       = 1'b0;
               if (in_type == REQ_INSERT) begin
                  if (count_ff >= cnt_type'(CAPACITY)) begin
                     res_status_in = ST_FULL;
                     state_in      = S_DONE;
                  end else if (in_pos == '0 ||
                               {1'b0, in_pos} > ({1'b0, count_ff} + 8'd1)) begin
                     res_status_in = ST_BAD_POS;
                     state_in      = S_DONE;
                  end else begin
                     ins_addr_in = idx_type'(in_pos - 7'd1);
                     left_in     = count_ff - cnt_type'(in_pos - 7'd1);
                     ptr_in      = count_ff - cnt_type'(1);
                     state_in    = S_MOVE;
                  end
               end else if (count_ff == '0) begin
                  res_status_in = ST_EMPTY;
                  state_in      = S_DONE;
               end else if (in_type == REQ_READ) begin
                  ptr_in   = '0;
                  state_in = S_RDISS;
               end else begin
                  ptr_in   = '0;
                  state_in = S_SCAN;
               end
            end
         end
         S_SCAN: begin
            if (ptr_ff < count_ff) begin
               ram_re      = 1'b1;
               pend_in     = 1'b1;
               pend_idx_in = ptr_ff[IDX_W-1:0];
               ptr_in      = ptr_ff + cnt_type'(1);
            end
            if (pend_ff && rd_word == value_ff) begin
               pend_in = 1'b0;
               if (op_ff == REQ_SEARCH) begin
                  res_index_in = pend_idx_ff;
                  state_in     = S_DONE;
               end else begin
                  left_in  = count_ff - cnt_type'(1) - cnt_type'(pend_idx_ff);
                  ptr_in   = cnt_type'(pend_idx_ff) + cnt_type'(1);
                  state_in = S_MOVE;
               end
            end else if (pend_ff && cnt_type'(pend_idx_ff) == count_ff - cnt_type'(1)) begin
               pend_in       = 1'b0;
               res_status_in = ST_NOT_FOUND;
               state_in      = S_DONE;
            end
         end
         S_MOVE: begin
            if (pend_ff) begin
               ram_we             = 1'b1;
               valid_in[ram_waddr] = 1'b1;
            end
            if (left_ff != '0) begin
               ram_re  = 1'b1;
               pend_in = 1'b1;
               left_in = left_ff - cnt_type'(1);
               if (op_ff == REQ_INSERT) begin
                  pend_idx_in = ptr_ff[IDX_W-1:0] + idx_type'(1);
                  ptr_in      = ptr_ff - cnt_type'(1);
               end else begin
                  pend_idx_in = ptr_ff[IDX_W-1:0] - idx_type'(1);
                  ptr_in      = ptr_ff + cnt_type'(1);
               end
            end else if (!pend_ff) begin
               if (op_ff == REQ_INSERT) begin
                  state_in = S_PUTV;
               end else begin
                  count_in = count_ff - cnt_type'(1);
                  state_in = S_DONE;
               end
            end
         end
         S_PUTV: begin
            ram_we                = 1'b1;
            ram_waddr             = ins_addr_ff;
            ram_wdata             = value_ff;
            valid_in[ins_addr_ff] = 1'b1;
            count_in              = count_ff + cnt_type'(1);
            state_in              = S_DONE;
         end
         S_DONE: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {count_ff, data_type'(0), res_index_ff, res_status_ff};
               rsp_last_in  = 1'b1;
               state_in     = S_IDLE;
            end
         end
         S_RDISS: begin
            if (slot_free) begin
               ram_re   = 1'b1;
               state_in = S_RDLOAD;
            end
         end
         S_RDLOAD: begin
            rsp_valid_in = 1'b1;
            rsp_data_in  = {count_ff, rd_word, ptr_ff[IDX_W-1:0], ST_OK};
            rsp_last_in  = (ptr_ff == count_ff - cnt_type'(1));
            ptr_in       = ptr_ff + cnt_type'(1);
            state_in     = (ptr_ff == count_ff - cnt_type'(1)) ? S_IDLE : S_RDISS;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= cnt_type'(INIT_COUNT);
         valid_ff     <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         valid_ff     <= valid_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      value_ff      <= value_in;
      ins_addr_ff   <= ins_addr_in;
      ptr_ff        <= ptr_in;
      left_ff       <= left_in;
      pend_idx_ff   <= pend_idx_in;
      res_status_ff <= res_status_in;
      res_index_ff  <= res_index_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_last_ff   <= rsp_last_in;
      if (ram_re) begin
         rd_vld_ff <= valid_ff[ram_raddr];
      end
   end

`ifndef NO_ASSERTIONS
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= cnt_type'(CAPACITY))
      else $error("live count exceeds capacity");

   a_write_state: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> (state_ff == S_MOVE || state_ff == S_PUTV))
      else $error("list write outside an update");

   a_insert_count: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_PUTV |=> count_ff == $past(count_ff) + cnt_type'(1))
      else $error("insert did not advance the count");

   a_read_slot: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_RDLOAD |-> !rsp_valid_ff)
      else $error("read beat would overwrite a waiting beat");
`endif

endmodule

[tb/sv/array_list_engine_test.sv]
// Self-checking testbench for the array list engine: directed table, then random traffic.
module array_list_engine_test
   import alm_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [STAT_W-1:0] status;
      idx_type           index;
      data_type          item;
      cnt_type           count;
      logic              last;
   } list_rsp_type;

   typedef struct packed {
      logic [REQ_W-1:0]  kind;
      data_type          val;
      logic [POS_W-1:0]  pos;
      bit                typed;
      logic [STAT_W-1:0] st;
      idx_type           idx;
      cnt_type           cnt;
   } list_req_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [47:0] req_tdata = '0;   // req_type[1:0], value[33:2], position[40:34], zero pad
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [47:0] rsp_tdata;        // status[2:0], index[8:3], item_value[40:9], entry_count[47:41]
   logic        rsp_tlast;

   data_type     list_mem [CAPACITY];
   int           list_len;
   list_rsp_type step_rsp [$];
   list_rsp_type expected_rsp [$];
   int           mismatch_count = 0;
   int           send_idle_pct = 0;
   int           recv_idle_pct = 0;
   int           stall_left = 0;
   bit           stall_request = 1'b0;

   list_req_type directed_rows [28] = '{
      '{REQ_SEARCH, 32'h0000_0000, 7'd1,   1'b1, ST_OK,        6'd0, 7'd10},
      '{REQ_SEARCH, 32'h7FFF_FFFF, 7'd1,   1'b1, ST_NOT_FOUND, 6'd0, 7'd10},
      '{REQ_INSERT, 32'h0000_0001, 7'd0,   1'b1, ST_BAD_POS,   6'd0, 7'd10},
      '{REQ_INSERT, 32'h0000_0002, 7'd12,  1'b1, ST_BAD_POS,   6'd0, 7'd10},
      '{REQ_INSERT, 32'hFFFF_FFFF, 7'd127, 1'b1, ST_BAD_POS,   6'd0, 7'd10},
      '{REQ_INSERT, 32'h8000_0000, 7'd1,   1'b1, ST_OK,        6'd0, 7'd11},
      '{REQ_INSERT, 32'h7FFF_FFFF, 7'd12,  1'b1, ST_OK,        6'd0, 7'd12},
      '{REQ_INSERT, 32'hFFFF_FFFF, 7'd6,   1'b1, ST_OK,        6'd0, 7'd13},
      '{REQ_SEARCH, 32'hFFFF_FFFF, 7'd0,   1'b1, ST_OK,        6'd5, 7'd13},
      '{REQ_READ,   32'h0000_0000, 7'd0,   1'b0, ST_OK,        6'd0, 7'd0},
      '{REQ_DELETE, 32'h0000_0000, 7'd0,   1'b1, ST_OK,        6'd0, 7'd12},
      '{REQ_DELETE, 32'h0000_3039, 7'd0,   1'b1, ST_NOT_FOUND, 6'd0, 7'd12},
      '{REQ_DELETE, 32'h8000_0000, 7'd0,   1'b1, ST_OK,        6'd0, 7'd11},
      '{REQ_DELETE, 32'h7FFF_FFFF, 7'd0,   1'b1, ST_OK,        6'd0, 7'd10},
      '{REQ_DELETE, 32'hFFFF_FFFF, 7'd0,   1'b1, ST_OK,        6'd0, 7'd9},
      '{REQ_DELETE, 32'h0000_0000, 7'd0,   1'b1, ST_OK,        6'd0, 7'd8},
      '{REQ_DELETE, 32'h0000_0000, 7'd0,   1'b1, ST_OK,        6'd0, 7'd7},
      '{REQ_DELETE, 32'h0000_0000, 7'd0,   1'b1, ST_OK,        6'd0, 7'd6},
      '{REQ_DELETE, 32'h0000_0000, 7'd0,   1'b1, ST_OK,        6'd0, 7'd5},
      '{REQ_DELETE, 32'h0000_0000, 7'd0,   1'b1, ST_OK,        6'd0, 7'd4},
      '{REQ_DELETE, 32'h0000_0000, 7'd0,   1'b1, ST_OK,        6'd0, 7'd3},
      '{REQ_DELETE, 32'h0000_0000, 7'd0,   1'b1, ST_OK,        6'd0, 7'd2},
      '{REQ_DELETE, 32'h0000_0000, 7'd0,   1'b1, ST_OK,        6'd0, 7'd1},
      '{REQ_DELETE, 32'h0000_0000, 7'd0,   1'b1, ST_OK,        6'd0, 7'd0},
      '{REQ_DELETE, 32'h0000_0000, 7'd0,   1'b1, ST_EMPTY,     6'd0, 7'd0},
      '{REQ_SEARCH, 32'h0000_0000, 7'd0,   1'b1, ST_EMPTY,     6'd0, 7'd0},
      '{REQ_READ,   32'h0000_0000, 7'd0,   1'b1, ST_EMPTY,     6'd0, 7'd0},
      '{REQ_INSERT, 32'h0000_0005, 7'd2,   1'b1, ST_BAD_POS,   6'd0, 7'd0}
   };

   array_list_engine i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      foreach (list_mem[i]) list_mem[i] = '0;
      list_len = INIT_COUNT;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
   end

   initial begin
      #5ms;
      $display("== FAIL ==");
      $finish;
   end

   task automatic note_result(input logic [STAT_W-1:0] status, input int index,
                              input data_type item, input bit last);
      step_rsp.push_back('{status, idx_type'(index), item, cnt_type'(list_len), last});
   endtask

   task automatic apply_request(input logic [REQ_W-1:0] kind, input data_type val,
                                input logic [POS_W-1:0] pos);
      int hit;
      step_rsp.delete();
      if (kind == REQ_INSERT) begin
         if (list_len >= CAPACITY) begin
            note_result(ST_FULL, 0, '0, 1'b1);
         end else if (int'(pos) < 1 || int'(pos) > list_len + 1) begin
            note_result(ST_BAD_POS, 0, '0, 1'b1);
         end else begin
            for (int i = list_len; i > int'(pos) - 1; i--) list_mem[i] = list_mem[i-1];
            list_mem[int'(pos) - 1] = val;
            list_len++;
            note_result(ST_OK, 0, '0, 1'b1);
         end
      end else if (list_len == 0) begin
         note_result(ST_EMPTY, 0, '0, 1'b1);
      end else if (kind == REQ_READ) begin
         for (int i = 0; i < list_len; i++)
            note_result(ST_OK, i, list_mem[i], i == list_len - 1);
      end else begin
         hit = 0;
         while (hit < list_len && list_mem[hit] != val) hit++;
         if (hit >= list_len) begin
            note_result(ST_NOT_FOUND, 0, '0, 1'b1);
         end else if (kind == REQ_SEARCH) begin
            note_result(ST_OK, hit, '0, 1'b1);
         end else begin
            for (int i = hit; i + 1 < list_len; i++) list_mem[i] = list_mem[i+1];
            list_len--;
            note_result(ST_OK, 0, '0, 1'b1);
         end
      end
   endtask

   task automatic send_req(input list_req_type row);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {7'd0, row.pos, row.val, row.kind};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      apply_request(row.kind, row.val, row.pos);
      if (row.typed)
         expected_rsp.push_back('{row.st, row.idx, data_type'(0), row.cnt, 1'b1});
      else
         foreach (step_rsp[k]) expected_rsp.push_back(step_rsp[k]);
   endtask

   function automatic list_req_type make_req(input logic [REQ_W-1:0] kind, input data_type val,
                                             input logic [POS_W-1:0] pos);
      return '{kind, val, pos, 1'b0, ST_OK, idx_type'(0), cnt_type'(0)};
   endfunction

   task automatic send_random();
      int pick;
      logic [REQ_W-1:0] kind;
      data_type val;
      logic [POS_W-1:0] pos;
      pick = $urandom_range(99);
      kind = (pick < 45) ? REQ_INSERT : (pick < 65) ? REQ_DELETE :
             (pick < 85) ? REQ_SEARCH : REQ_READ;
      pick = $urandom_range(99);
      if (list_len > 0 && pick < 50)
         val = list_mem[$urandom_range(list_len - 1)];
      else if (pick < 75)
         val = $urandom_range(8) - 4;
      else
         val = $urandom;
      if ($urandom_range(99) < 85)
         pos = POS_W'($urandom_range(list_len + 1, 1));
      else
         pos = POS_W'($urandom_range(127));
      send_req(make_req(kind, val, pos));
   endtask

   task automatic check_beat();
      list_rsp_type got;
      list_rsp_type want;
      got = '{rsp_tdata[2:0], rsp_tdata[8:3], rsp_tdata[40:9], rsp_tdata[47:41], rsp_tlast};
      if (expected_rsp.size() == 0) begin
         $display("%0t: unexpected result beat st=%0d idx=%0d val=%h cnt=%0d last=%0b",
                  $realtime, got.status, got.index, got.item, got.count, got.last);
         mismatch_count++;
      end else begin
         want = expected_rsp.pop_front();
         if (got.status != want.status || got.index != want.index || got.item != want.item ||
             got.count != want.count || got.last != want.last) begin
            $display("%0t: expected %0d/%0d/%h/%0d/%0b, got %0d/%0d/%h/%0d/%0b",
                     $realtime, want.status, want.index, want.item, want.count, want.last,
                     got.status, got.index, got.item, got.count, got.last);
            mismatch_count++;
         end
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) check_beat();
      if (stall_request) begin
         stall_left = 400;
         stall_request = 1'b0;
      end
      if (stall_left > 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   initial begin
      send_idle_pct = 32;
      recv_idle_pct = 81;
      wait (!reset);
      @(posedge clock);
      foreach (directed_rows[r]) send_req(directed_rows[r]);
      repeat (12) send_random();

      send_idle_pct = 81;
      recv_idle_pct = 32;
      repeat (12) send_random();

      send_idle_pct = 0;
      recv_idle_pct = 0;
      stall_request = 1'b1;
      repeat (4) send_random();
      while (list_len < CAPACITY)
         send_req(make_req(REQ_INSERT, $urandom, POS_W'($urandom_range(list_len + 1, 1))));
      repeat (2) send_req(make_req(REQ_INSERT, $urandom, POS_W'($urandom_range(127))));
      send_req(make_req(REQ_READ, $urandom, POS_W'($urandom_range(127))));
      repeat (8) send_random();

      req_tvalid <= 1'b0;
      while (expected_rsp.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (mismatch_count == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule
